/* rtl/cdfa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character-class DFA stepper package
// Shared payload types, rule store entry, control word layout and codes.
// ----------------------------------------------------------------------------
package cdfa_pkg;

  // Fixed field widths.
  localparam int STATE_W  = 4;
  localparam int SLOT_W   = 6;
  localparam int CHAR_W   = 8;
  localparam int RCHAR_W  = 7;
  localparam int COUNT_W  = 3;
  localparam int AID_W    = 5;
  localparam int PACKED_ACTIONS = 4;
  localparam int IDS_W    = AID_W * PACKED_ACTIONS;
  localparam int ACT_W    = $clog2(PACKED_ACTIONS);

  // Number of slots the slot field can address.
  localparam int SLOT_RANGE = 1 << SLOT_W;

  // Automaton constants.
  localparam int NUM_RULES_DEF  = 64;
  localparam int NUM_STATES     = 16;
  localparam int MAX_ACTIONS    = 4;
  localparam int NUM_ACTION_IDS = 32;

  // Request type codes.
  localparam logic [1:0] REQ_WRITE   = 2'd0;
  localparam logic [1:0] REQ_RESTART = 2'd1;
  localparam logic [1:0] REQ_CHAR    = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [SLOT_W-1:0]  rule_slot;
    logic               rule_used;
    logic [STATE_W-1:0] rule_from;
    logic [RCHAR_W-1:0] rule_low;
    logic [RCHAR_W-1:0] rule_high;
    logic [STATE_W-1:0] rule_to;
    logic [COUNT_W-1:0] rule_action_count;
    logic [IDS_W-1:0]   rule_action_ids;
    logic [CHAR_W-1:0]  char_in;
  } req_t;

  typedef struct packed {
    logic [STATE_W-1:0] from_state;
    logic [STATE_W-1:0] to_state;
    logic [CHAR_W-1:0]  char_out;
    logic               action_valid;
    logic [AID_W-1:0]   action_id;
    logic               no_match;
    logic               last;
  } rsp_t;

  // One rule store entry.
  typedef struct packed {
    logic               used;
    logic [STATE_W-1:0] src;
    logic [RCHAR_W-1:0] lo;
    logic [RCHAR_W-1:0] hi;
    logic [STATE_W-1:0] dst;
    logic [COUNT_W-1:0] count;
    logic [IDS_W-1:0]   ids;
  } rule_t;

  localparam int RULE_W = $bits(rule_t);

  // Datapath operations selected by the control word.
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
  localparam logic [OP_W-1:0] OP_CLR_PTR  = 4'd1;
  localparam logic [OP_W-1:0] OP_SCAN     = 4'd2;
  localparam logic [OP_W-1:0] OP_LOAD_ACT = 4'd3;
  localparam logic [OP_W-1:0] OP_EMIT_ACT = 4'd4;
  localparam logic [OP_W-1:0] OP_COMMIT   = 4'd5;
  localparam logic [OP_W-1:0] OP_EMIT_NM  = 4'd6;
  localparam logic [OP_W-1:0] OP_WRITE    = 4'd7;
  localparam logic [OP_W-1:0] OP_RESTART  = 4'd8;

  // Jump conditions.
  localparam int CND_W = 4;
  localparam logic [CND_W-1:0] CND_NEVER       = 4'd0;
  localparam logic [CND_W-1:0] CND_ALWAYS      = 4'd1;
  localparam logic [CND_W-1:0] CND_IN_FIRE     = 4'd2;
  localparam logic [CND_W-1:0] CND_REQ_WRITE   = 4'd3;
  localparam logic [CND_W-1:0] CND_REQ_RESTART = 4'd4;
  localparam logic [CND_W-1:0] CND_NOT_CHAR    = 4'd5;
  localparam logic [CND_W-1:0] CND_HALTED      = 4'd6;
  localparam logic [CND_W-1:0] CND_SCAN_STOP   = 4'd7;
  localparam logic [CND_W-1:0] CND_NOT_GOOD    = 4'd8;
  localparam logic [CND_W-1:0] CND_EMIT_DONE   = 4'd9;
  localparam logic [CND_W-1:0] CND_OUT_FREE    = 4'd10;

  localparam int UPC_W = 4;

  // Control word: when cond holds, jump to target; otherwise hold or advance.
  typedef struct packed {
    logic             accept;
    logic [OP_W-1:0]  op;
    logic [CND_W-1:0] cond;
    logic             hold;
    logic [UPC_W-1:0] target;
  } ucode_t;

  // Status flags from the datapath that the sequencer tests.
  typedef struct packed {
    logic in_fire;
    logic req_write;
    logic req_restart;
    logic req_char;
    logic halted;
    logic scan_stop;
    logic rule_good;
    logic emit_done;
    logic out_free;
  } seq_flags_t;

endpackage

/* rtl/cdfa_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cdfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/cdfa_useq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Microcode sequencer
// Step counter and control store that drive the stepper datapath.
// ----------------------------------------------------------------------------
module cdfa_useq
  import cdfa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  seq_flags_t flags,
  output ucode_t     cw
);

  // Step addresses.
  localparam logic [UPC_W-1:0] S_IDLE    = 4'd0;
  localparam logic [UPC_W-1:0] S_DEC_WR  = 4'd1;
  localparam logic [UPC_W-1:0] S_DEC_RS  = 4'd2;
  localparam logic [UPC_W-1:0] S_DEC_CH  = 4'd3;
  localparam logic [UPC_W-1:0] S_DEC_HLT = 4'd4;
  localparam logic [UPC_W-1:0] S_PRIME0  = 4'd5;
  localparam logic [UPC_W-1:0] S_PRIME1  = 4'd6;
  localparam logic [UPC_W-1:0] S_SCAN    = 4'd7;
  localparam logic [UPC_W-1:0] S_CHECK   = 4'd8;
  localparam logic [UPC_W-1:0] S_LOADACT = 4'd9;
  localparam logic [UPC_W-1:0] S_EMIT    = 4'd10;
  localparam logic [UPC_W-1:0] S_COMMIT  = 4'd11;
  localparam logic [UPC_W-1:0] S_NOMATCH = 4'd12;
  localparam logic [UPC_W-1:0] S_WRITE   = 4'd13;
  localparam logic [UPC_W-1:0] S_RESTART = 4'd14;
  localparam logic [UPC_W-1:0] S_SPARE   = 4'd15;

  logic [UPC_W-1:0] upc;
  logic [UPC_W-1:0] upc_next;
  logic             take;

  // Control store.
  always_comb begin
    unique case (upc)
      S_IDLE:    cw = '{1'b1, OP_NONE,     CND_IN_FIRE,     1'b1, S_DEC_WR};
      S_DEC_WR:  cw = '{1'b0, OP_NONE,     CND_REQ_WRITE,   1'b0, S_WRITE};
      S_DEC_RS:  cw = '{1'b0, OP_NONE,     CND_REQ_RESTART, 1'b0, S_RESTART};
      S_DEC_CH:  cw = '{1'b0, OP_NONE,     CND_NOT_CHAR,    1'b0, S_IDLE};
      S_DEC_HLT: cw = '{1'b0, OP_NONE,     CND_HALTED,      1'b0, S_NOMATCH};
      S_PRIME0:  cw = '{1'b0, OP_CLR_PTR,  CND_NEVER,       1'b0, S_IDLE};
      S_PRIME1:  cw = '{1'b0, OP_SCAN,     CND_NEVER,       1'b0, S_IDLE};
      S_SCAN:    cw = '{1'b0, OP_SCAN,     CND_SCAN_STOP,   1'b1, S_CHECK};
      S_CHECK:   cw = '{1'b0, OP_NONE,     CND_NOT_GOOD,    1'b0, S_NOMATCH};
      S_LOADACT: cw = '{1'b0, OP_LOAD_ACT, CND_NEVER,       1'b0, S_IDLE};
      S_EMIT:    cw = '{1'b0, OP_EMIT_ACT, CND_EMIT_DONE,   1'b1, S_COMMIT};
      S_COMMIT:  cw = '{1'b0, OP_COMMIT,   CND_ALWAYS,      1'b0, S_IDLE};
      S_NOMATCH: cw = '{1'b0, OP_EMIT_NM,  CND_OUT_FREE,    1'b1, S_IDLE};
      S_WRITE:   cw = '{1'b0, OP_WRITE,    CND_ALWAYS,      1'b0, S_IDLE};
      S_RESTART: cw = '{1'b0, OP_RESTART,  CND_ALWAYS,      1'b0, S_IDLE};
      S_SPARE:   cw = '{1'b0, OP_NONE,     CND_ALWAYS,      1'b0, S_IDLE};
      default:   cw = '{1'b0, OP_NONE,     CND_ALWAYS,      1'b0, S_IDLE};
    endcase
  end

  always_comb begin
    unique case (cw.cond)
      CND_NEVER:       take = 1'b0;
      CND_ALWAYS:      take = 1'b1;
      CND_IN_FIRE:     take = flags.in_fire;
      CND_REQ_WRITE:   take = flags.req_write;
      CND_REQ_RESTART: take = flags.req_restart;
      CND_NOT_CHAR:    take = !flags.req_char;
      CND_HALTED:      take = flags.halted;
      CND_SCAN_STOP:   take = flags.scan_stop;
      CND_NOT_GOOD:    take = !flags.rule_good;
      CND_EMIT_DONE:   take = flags.emit_done;
      CND_OUT_FREE:    take = flags.out_free;
      default:         take = 1'b1;
    endcase
  end

  always_comb begin
    if (take) begin
      upc_next = cw.target;
    end else if (cw.hold) begin
      upc_next = upc;
    end else begin
      upc_next = upc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= S_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

`ifndef SYNTHESIS
  // A jump never lands on the unused step.
  a_no_spare: assert property (@(posedge clk) disable iff (rst) upc != S_SPARE)
    else $error("sequencer reached unused step");
  // The input is taken only in the idle step.
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    cw.accept |-> upc == S_IDLE)
    else $error("accept outside idle step");
  // A scan that has not stopped keeps scanning.
  a_scan_hold: assert property (@(posedge clk) disable iff (rst)
    upc == S_SCAN && !flags.scan_stop |=> upc == S_SCAN)
    else $error("scan left without a stop");
`endif

endmodule

/* rtl/char_class_dfa_stepper.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character-class DFA stepper
// Table-driven automaton with a loadable rule store, run by a microcoded
// sequencer over a rule scan datapath.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_ready  req_t: write, restart or char
//   rsp      out        rsp_valid / rsp_ready  rsp_t: one action result
//
// A character is scanned against the rule store, one store read per cycle over
// up to SLOTS slots, then yields one result per action, at least one; a miss
// or a halted character yields a single no-match result. Synchronous reset clears
// the state, the halt flag and the per-slot valid bits.
// A stalled result port holds the emit step; the next request waits until the
// previous one has handed its last result to the output register.
// ----------------------------------------------------------------------------
module char_class_dfa_stepper
  import cdfa_pkg::*;
#(
  parameter int NUM_RULES = NUM_RULES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  // Only the slots reachable by the slot field are stored; any further
  // slots can never be written and always read as unused.
  localparam int SLOTS = (NUM_RULES < SLOT_RANGE) ? NUM_RULES : SLOT_RANGE;
  localparam int AW    = $clog2(SLOTS);

  ucode_t     cw;
  seq_flags_t flags;

  // Latched request transaction.
  req_t item;

  logic [STATE_W-1:0] state;
  logic               halted;
  logic [SLOTS-1:0]   slot_valid;

  // Rule scan pointers: scan_ptr addresses the RAM, eval_ptr names the
  // entry whose data is on the read port.
  logic [AW-1:0] scan_ptr;
  logic [AW-1:0] eval_ptr;
  logic [RULE_W-1:0] rd_word;
  rule_t rd_rule;
  rule_t rule;
  logic  hit;
  logic  match;

  // Action emission.
  logic [ACT_W-1:0]   act_idx;
  logic [COUNT_W-1:0] act_n;
  logic [AID_W-1:0]   cur_id;
  logic               emit_last;

  logic in_fire;
  logic out_free;
  logic wr_en;

  cdfa_useq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .cw    (cw)
  );

  cdfa_ram #(
    .WIDTH (RULE_W),
    .DEPTH (SLOTS)
  ) u_store (
    .clk     (clk),
    .we      (wr_en),
    .wr_addr (item.rule_slot[AW-1:0]),
    .wr_data ({item.rule_used, item.rule_from, item.rule_low, item.rule_high,
               item.rule_to, item.rule_action_count, item.rule_action_ids}),
    .rd_addr (scan_ptr),
    .rd_data (rd_word)
  );

  function automatic logic [COUNT_W-1:0] clamp_count(logic [COUNT_W-1:0] c);
    int n;
    n = int'(c);
    if (n > MAX_ACTIONS) begin
      n = MAX_ACTIONS;
    end
    if (n > PACKED_ACTIONS) begin
      n = PACKED_ACTIONS;
    end
    return COUNT_W'(n);
  endfunction

  assign req_ready = cw.accept;
  assign in_fire   = req_valid && req_ready;
  assign out_free  = !rsp_valid || rsp_ready;
  assign wr_en     = (cw.op == OP_WRITE) && (int'(item.rule_slot) < SLOTS);

  assign rd_rule = rule_t'(rd_word);

  // A slot matches when it holds a live rule for the current state and its
  // range covers the character; bytes above 127 never fall in a range.
  assign match = slot_valid[eval_ptr] && rd_rule.used && (rd_rule.src == state) &&
                 !item.char_in[CHAR_W-1] &&
                 (item.char_in[RCHAR_W-1:0] >= rd_rule.lo) &&
                 (item.char_in[RCHAR_W-1:0] <= rd_rule.hi);

  assign cur_id    = rule.ids[act_idx*AID_W +: AID_W];
  assign emit_last = (act_n == '0) || (COUNT_W'(act_idx) == act_n - 1'b1);

  always_comb begin
    flags.in_fire     = in_fire;
    flags.req_write   = item.req_type == REQ_WRITE;
    flags.req_restart = item.req_type == REQ_RESTART;
    flags.req_char    = item.req_type == REQ_CHAR;
    flags.halted      = halted;
    flags.scan_stop   = match || (eval_ptr == AW'(SLOTS - 1));
    // A matching rule with a target beyond the state space counts as a miss.
    flags.rule_good   = hit && (int'(rule.dst) < NUM_STATES);
    flags.emit_done   = out_free && emit_last;
    flags.out_free    = out_free;
  end

  // Request capture, rule scan and action bookkeeping.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item <= req;
    end
    unique case (cw.op)
      OP_CLR_PTR: begin
        scan_ptr <= '0;
      end
      OP_SCAN: begin
        if (scan_ptr != AW'(SLOTS - 1)) begin
          scan_ptr <= scan_ptr + 1'b1;
        end
        eval_ptr <= scan_ptr;
        rule     <= rd_rule;
        hit      <= match;
      end
      OP_LOAD_ACT: begin
        act_idx <= '0;
        act_n   <= clamp_count(rule.count);
      end
      OP_EMIT_ACT: begin
        if (out_free) begin
          act_idx <= act_idx + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Architectural state and valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= '0;
      halted     <= 1'b0;
      slot_valid <= '0;
    end else begin
      unique case (cw.op)
        OP_COMMIT: begin
          state <= rule.dst;
        end
        OP_EMIT_NM: begin
          if (out_free) begin
            halted <= 1'b1;
          end
        end
        OP_WRITE: begin
          if (wr_en) begin
            slot_valid[item.rule_slot[AW-1:0]] <= 1'b1;
          end
        end
        OP_RESTART: begin
          state  <= '0;
          halted <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Output register: a result waits here while the sequencer moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((cw.op == OP_EMIT_ACT || cw.op == OP_EMIT_NM) && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (cw.op == OP_EMIT_ACT) begin
        rsp.from_state   <= state;
        rsp.to_state     <= rule.dst;
        rsp.char_out     <= item.char_in;
        rsp.action_valid <= (act_n != '0) && (int'(cur_id) < NUM_ACTION_IDS);
        rsp.action_id    <= (act_n != '0) ? cur_id : '0;
        rsp.no_match     <= 1'b0;
        rsp.last         <= emit_last;
      end else if (cw.op == OP_EMIT_NM) begin
        rsp.from_state   <= state;
        rsp.to_state     <= state;
        rsp.char_out     <= item.char_in;
        rsp.action_valid <= 1'b0;
        rsp.action_id    <= '0;
        rsp.no_match     <= 1'b1;
        rsp.last         <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  // A no-match result is always the single, action-free final result.
  a_nomatch_shape: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.no_match |-> rsp.last && !rsp.action_valid)
    else $error("malformed no-match result");
  // Halting goes together with handing out a no-match result.
  a_halt_reported: assert property (@(posedge clk) disable iff (rst)
    $rose(halted) |-> rsp_valid && rsp.no_match)
    else $error("halted without a no-match result");
  // A matched result never reports a target outside the state space.
  a_target_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.no_match |-> int'(rsp.to_state) < NUM_STATES)
    else $error("result target out of range");
  // The state only moves on a commit or a restart.
  a_state_move: assert property (@(posedge clk) disable iff (rst)
    cw.op != OP_COMMIT && cw.op != OP_RESTART |=> $stable(state))
    else $error("state changed outside commit or restart");
`endif

endmodule
